/* design/assert_macros.svh */
// Assertion macros for the word reversal block, included by reverse_letters_in_words_core.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, suspended while reset is held.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/rlw_pkg.sv */
// Package for the word reversal block: widths, constants and controller states.
// Depends on nothing; used by reverse_letters_in_words_core.
`timescale 1ns / 1ps

package rlw_pkg;

  // Word stack size and derived widths
  localparam int WORD_MAX = 32;
  localparam int CHAR_W   = 8;
  localparam int CNT_W    = $clog2(WORD_MAX + 1);
  localparam int ADDR_W   = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

  localparam logic [CNT_W-1:0]  WORD_MAX_C      = CNT_W'(WORD_MAX);
  localparam logic [CHAR_W-1:0] TERMINATOR      = 8'h00;
  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'h20;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_FILL = 4'b0001,
    ST_READ = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_LAST = 4'b1000
  } state_t;

endpackage

/* design/rlw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; read data holds while no read is issued.
`timescale 1ns / 1ps

module rlw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/reverse_letters_in_words_core.sv */
// Top level of the word reversal block: controller, word stack RAM, output register.
// Depends on rlw_pkg, rlw_ram and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one text byte per transaction. Ordinary bytes are stacked and give
//           no result; a byte equal to the separator register or byte 0 ends
//           the word.
//   out_* : for each ending byte, the stacked bytes in reverse order, then the
//           ending byte with out_tlast high. out_tuser flags a word that lost
//           bytes because the 32-entry stack was full.
//   cfg_* : cfg_we writes cfg_wdata into the separator register (space after
//           reset). Write only while the block is idle.
// Flow: word bytes are accepted while the block is in ST_FILL. An ending byte
//   with n stacked bytes then drains them: every stacked byte passes through
//   ST_READ, which issues its read on the single RAM read port, and ST_WAIT,
//   which loads it into the output register; ST_LAST then emits the ending
//   byte. Input is held off during the drain. The first result of a run thus
//   comes from ST_LAST if the word is empty, else from ST_WAIT.
// Reset: synchronous, active low; empties the stack and clears the overflow
//   and output valid flags; output payload and RAM contents are left as they are.
// Stall: a held result keeps its value; the drain pauses until it is taken.

`include "assert_macros.svh"

module reverse_letters_in_words_core (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream; tdata bits: [7:0] in_char
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  // Result stream; tdata bits: [7:0] out_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  // tuser bits: [0] word_overflow
  output logic       out_tuser,
  // Separator register write
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  rlw_pkg::state_t state_r, state_nxt;

  logic [rlw_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [rlw_pkg::CHAR_W-1:0] sep_r;
  logic [rlw_pkg::CHAR_W-1:0] term_r, term_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [rlw_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic                        in_fire;
  logic                        is_end;
  logic                        slot_free;
  logic                        ram_we;
  logic                        ram_re;
  logic [rlw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [rlw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [rlw_pkg::CNT_W-1:0]   count_dec;
  logic [rlw_pkg::CHAR_W-1:0]  ram_rdata;

  // Handshake and decode
  assign in_tready = (state_r == rlw_pkg::ST_FILL);
  assign in_fire   = in_tvalid && in_tready;
  assign is_end    = (in_tdata == sep_r) || (in_tdata == rlw_pkg::TERMINATOR);
  assign slot_free = !out_valid_r || out_tready;
  assign count_dec = count_r - rlw_pkg::CNT_W'(1);

  // Push at the current fill level, pop from the top while draining
  assign ram_we    = in_fire && !is_end && (count_r < rlw_pkg::WORD_MAX_C);
  assign ram_waddr = count_r[rlw_pkg::ADDR_W-1:0];
  assign ram_re    = (state_r == rlw_pkg::ST_READ);
  assign ram_raddr = count_dec[rlw_pkg::ADDR_W-1:0];

  rlw_ram #(
    .WIDTH (rlw_pkg::CHAR_W),
    .DEPTH (rlw_pkg::WORD_MAX)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Controller: fill the stack, then read and emit one byte at a time via ST_READ and ST_WAIT, ending byte via ST_LAST
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      rlw_pkg::ST_FILL: begin
        if (in_fire) begin
          if (is_end) begin
            term_nxt  = in_tdata;
            state_nxt = (count_r == '0) ? rlw_pkg::ST_LAST : rlw_pkg::ST_READ;
          end else if (count_r < rlw_pkg::WORD_MAX_C) begin
            count_nxt = count_r + rlw_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      rlw_pkg::ST_READ: begin
        state_nxt = rlw_pkg::ST_WAIT;
      end
      rlw_pkg::ST_WAIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = ovf_r;
          count_nxt     = count_dec;
          state_nxt     = (count_dec == '0) ? rlw_pkg::ST_LAST : rlw_pkg::ST_READ;
        end
      end
      rlw_pkg::ST_LAST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = term_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = rlw_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = rlw_pkg::ST_FILL;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlw_pkg::ST_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Separator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= rlw_pkg::SEPARATOR_RESET;
    end else if (cfg_we) begin
      sep_r <= cfg_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    term_r     <= term_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // Checks
  `ASSERT_SYNC(a_count_bound, count_r <= rlw_pkg::WORD_MAX_C, "stack count past capacity")
  `ASSERT_SYNC(a_read_nonempty, (state_r == rlw_pkg::ST_READ) |-> (count_r != '0),
               "stack read issued on an empty stack")
  `ASSERT_SYNC(a_last_emits, (state_r == rlw_pkg::ST_LAST && slot_free) |=>
               (out_valid_r && out_last_r && state_r == rlw_pkg::ST_FILL && count_r == '0),
               "ending byte not emitted as closing result")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for reverse_letters_in_words_core: drives text bytes, predicts
// each run of reversed word bytes in its own word model and checks every output transaction.
// Depends on rlw_pkg and the design files of the word reversal block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * rlw_pkg::WORD_MAX + 8;

  typedef struct packed {
    logic [rlw_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       ovf;
  } rev_byte_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [rlw_pkg::CHAR_W-1:0] in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [rlw_pkg::CHAR_W-1:0] out_tdata;
  logic                       out_tlast;
  logic                       out_tuser;
  logic                       cfg_we = 1'b0;
  logic [rlw_pkg::CHAR_W-1:0] cfg_wdata = '0;

  // Word model: stacked bytes, drop flag and separator as the block should hold them
  logic [rlw_pkg::CHAR_W-1:0] word_buf [rlw_pkg::WORD_MAX];
  int                         word_len = 0;
  logic                       word_dropped = 1'b0;
  logic [rlw_pkg::CHAR_W-1:0] sep_char = rlw_pkg::SEPARATOR_RESET;

  rev_byte_t reversed_bytes[$];
  int        err_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        rx_hold_cycles = 0;

  reverse_letters_in_words_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL reverse_letters_in_words_core");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin
    rev_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reversed_bytes.size() == 0) begin
        $error("unexpected output transaction: out_char %02h", out_tdata);
        err_count++;
      end else begin
        want = reversed_bytes.pop_front();
        if (out_tdata !== want.ch) begin
          $error("out_char: expected %02h, actual %02h", want.ch, out_tdata);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("run_last: expected %0b, actual %0b", want.last, out_tlast);
          err_count++;
        end
        if (out_tuser !== want.ovf) begin
          $error("word_overflow: expected %0b, actual %0b", want.ovf, out_tuser);
          err_count++;
        end
      end
    end
  end

  // Advance the word model by one accepted byte; an ending byte flushes the reversed word
  function automatic void predict_reversal(input logic [rlw_pkg::CHAR_W-1:0] ch);
    if (ch == sep_char || ch == rlw_pkg::TERMINATOR) begin
      for (int i = word_len - 1; i >= 0; i--)
        reversed_bytes.push_back(rev_byte_t'{ch: word_buf[i], last: 1'b0, ovf: word_dropped});
      reversed_bytes.push_back(rev_byte_t'{ch: ch, last: 1'b1, ovf: word_dropped});
      word_len = 0;
      word_dropped = 1'b0;
    end else if (word_len < rlw_pkg::WORD_MAX) begin
      word_buf[word_len] = ch;
      word_len++;
    end else begin
      word_dropped = 1'b1;
    end
  endfunction

  // Offer one byte, with random idle cycles first, and predict once accepted
  task automatic send_char(input logic [rlw_pkg::CHAR_W-1:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    predict_reversal(ch);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Hold until every expected byte has arrived and the block has settled
  task automatic wait_for_drain();
    while (reversed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_separator(input logic [rlw_pkg::CHAR_W-1:0] v);
    stop_sending();
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sep_char = v;
  endtask

  function automatic logic [rlw_pkg::CHAR_W-1:0] random_word_byte();
    logic [rlw_pkg::CHAR_W-1:0] b;
    do b = rlw_pkg::CHAR_W'($urandom_range(1, 255)); while (b == sep_char);
    return b;
  endfunction

  // Short words, extreme bytes, empty words and terminators at the reset separator
  task automatic test_basic_words();
    send_char(8'h41);
    send_char(8'h42);
    send_char(sep_char);
    send_char(sep_char);
    send_char(8'hFF);
    send_char(8'h01);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(rlw_pkg::TERMINATOR);
    send_char(rlw_pkg::TERMINATOR);
  endtask

  // Word one byte longer than the stack: extra byte dropped, run flagged
  task automatic test_word_overflow();
    for (int i = 0; i <= rlw_pkg::WORD_MAX; i++) send_char(random_word_byte());
    send_char(sep_char);
  endtask

  // Separator register at both extremes, then back to space
  task automatic test_separator_values();
    set_separator(8'h00);
    send_char(8'h61);
    send_char(8'h62);
    send_char(rlw_pkg::TERMINATOR);
    set_separator(8'hFF);
    send_char(8'h20);
    send_char(8'h63);
    send_char(8'hFF);
    send_char(8'h64);
    send_char(rlw_pkg::TERMINATOR);
    set_separator(rlw_pkg::SEPARATOR_RESET);
  endtask

  // Hold off the receiver while a word and more runs are offered, then pause
  task automatic test_output_stall();
    rx_hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_char(random_word_byte());
    send_char(sep_char);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(rlw_pkg::TERMINATOR);
    stop_sending();
    wait_for_drain();
  endtask

  // Mostly well-formed words with random content, some noise bytes
  task automatic test_random_text(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_char(rlw_pkg::CHAR_W'($urandom_range(255)));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) send_char(random_word_byte());
        send_char(($urandom_range(3) == 0) ? rlw_pkg::TERMINATOR : sep_char);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    // Reset once
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 64;
    test_basic_words();
    test_word_overflow();
    test_separator_values();
    test_output_stall();

    test_random_text(12, 14, 64);
    set_separator(rlw_pkg::CHAR_W'($urandom_range(1, 255)));
    test_random_text(12, 64, 14);
    set_separator(rlw_pkg::SEPARATOR_RESET);
    test_random_text(10, 0, 0);

    stop_sending();
    wait_for_drain();
    if (err_count == 0) begin
      $display("PASS reverse_letters_in_words_core");
    end else begin
      $display("FAIL reverse_letters_in_words_core");
    end
    $finish;
  end

endmodule
